/* src/dvrt_pkg.sv */
package dvrt_pkg;

  localparam int NODES_DEF = 8;
  localparam int MAX_NODES = 8;
  localparam int CNT_W     = 4;
  localparam int COST_W    = 16;

  localparam logic [COST_W-1:0] UNREACH    = 16'hFFFF;
  localparam logic [2:0]        MISS_LIMIT = 3'd3;
  localparam logic [2:0]        MISS_MAX   = 3'd7;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_SET     = 3'd1;
  localparam logic [2:0] OP_DISABLE = 3'd2;
  localparam logic [2:0] OP_VECTOR  = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  localparam logic CFG_OWN_NODE = 1'b0;
  localparam logic CFG_NBR_MASK = 1'b1;

  typedef struct packed {
    logic [2:0]        operation;
    logic [2:0]        peer;
    logic [2:0]        dest;
    logic [COST_W-1:0] cost_in;
    logic              last;
  } in_t;

  typedef struct packed {
    logic              status;
    logic [2:0]        next_hop;
    logic [COST_W-1:0] cost_out;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_RX_D,
    S_RX_CUR,
    S_RX_B,
    S_RX_A,
    S_RX_S,
    S_RX_WR,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_OWN_DEST,
    RD_OWN_D,
    RD_OWN_B,
    RD_B_D
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ITEM,
    WR_DIS,
    WR_TICK,
    WR_RELAX
  } wr_sel_t;

  typedef struct packed {
    logic    load_item;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    d_set0;
    logic    d_set1;
    logic    d_inc;
    logic    b_set1;
    logic    b_inc;
    logic    cap_cur;
    logic    cap_a;
    logic    cmp_sum;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       last;
    logic       vec_ok;
    logic       dis_ok;
    logic       own_ok;
    logic       d_end;
    logic       d_is_own;
    logic       b_end;
    logic       b_nbr;
    logic       out_full;
  } sts_t;

endpackage

/* src/dvrt_ram.sv */
module dvrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/dvrt_ctrl.sv */
module dvrt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dvrt_pkg::sts_t sts,
  output dvrt_pkg::cmd_t cmd
);

  dvrt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dvrt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = dvrt_pkg::RD_NONE;
    cmd.wr_sel = dvrt_pkg::WR_NONE;
    in_ready   = 1'b0;
    unique case (state_r)
      dvrt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = dvrt_pkg::S_EXEC;
        end
      end
      dvrt_pkg::S_EXEC: begin
        state_nxt = dvrt_pkg::S_OUT;
        unique case (sts.op)
          dvrt_pkg::OP_LOAD, dvrt_pkg::OP_SET: begin
            cmd.wr_sel = dvrt_pkg::WR_ITEM;
          end
          dvrt_pkg::OP_VECTOR: begin
            cmd.wr_sel = dvrt_pkg::WR_ITEM;
            if (sts.vec_ok && sts.last) begin
              cmd.d_set1 = 1'b1;
              state_nxt  = dvrt_pkg::S_RX_D;
            end
          end
          dvrt_pkg::OP_DISABLE: begin
            if (sts.dis_ok) begin
              cmd.wr_sel = dvrt_pkg::WR_DIS;
              cmd.d_set1 = 1'b1;
              state_nxt  = dvrt_pkg::S_RX_D;
            end
          end
          dvrt_pkg::OP_TICK: begin
            cmd.d_set0 = 1'b1;
            state_nxt  = dvrt_pkg::S_TICK;
          end
          dvrt_pkg::OP_READ: begin
            cmd.rd_sel = dvrt_pkg::RD_OWN_DEST;
          end
          default: begin
          end
        endcase
      end
      dvrt_pkg::S_TICK: begin
        if (sts.d_end || !sts.own_ok) begin
          state_nxt = dvrt_pkg::S_OUT;
        end else begin
          cmd.wr_sel = dvrt_pkg::WR_TICK;
          cmd.d_inc  = 1'b1;
        end
      end
      dvrt_pkg::S_RX_D: begin
        priority if (sts.d_end || !sts.own_ok) begin
          state_nxt = dvrt_pkg::S_OUT;
        end else if (sts.d_is_own) begin
          cmd.d_inc = 1'b1;
        end else begin
          cmd.rd_sel = dvrt_pkg::RD_OWN_D;
          cmd.b_set1 = 1'b1;
          state_nxt  = dvrt_pkg::S_RX_CUR;
        end
      end
      dvrt_pkg::S_RX_CUR: begin
        cmd.cap_cur = 1'b1;
        state_nxt   = dvrt_pkg::S_RX_B;
      end
      dvrt_pkg::S_RX_B: begin
        priority if (sts.b_end) begin
          state_nxt = dvrt_pkg::S_RX_WR;
        end else if (!sts.b_nbr) begin
          cmd.b_inc = 1'b1;
        end else begin
          cmd.rd_sel = dvrt_pkg::RD_OWN_B;
          state_nxt  = dvrt_pkg::S_RX_A;
        end
      end
      dvrt_pkg::S_RX_A: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_sel = dvrt_pkg::RD_B_D;
        state_nxt  = dvrt_pkg::S_RX_S;
      end
      dvrt_pkg::S_RX_S: begin
        cmd.cmp_sum = 1'b1;
        cmd.b_inc   = 1'b1;
        state_nxt   = dvrt_pkg::S_RX_B;
      end
      dvrt_pkg::S_RX_WR: begin
        cmd.wr_sel = dvrt_pkg::WR_RELAX;
        cmd.d_inc  = 1'b1;
        state_nxt  = dvrt_pkg::S_RX_D;
      end
      dvrt_pkg::S_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = dvrt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dvrt_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == dvrt_pkg::S_EXEC)
    else $error("accepted transfer did not start execution");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_full)
    else $error("result loaded over a pending one");
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_sel != dvrt_pkg::WR_NONE |-> cmd.rd_sel == dvrt_pkg::RD_NONE)
    else $error("table read and write in one cycle");
`endif

endmodule

/* src/dvrt_dp.sv */
module dvrt_dp #(
  parameter int NODES = dvrt_pkg::NODES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dvrt_pkg::in_t  in_data,
  input  logic           cfg_valid,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data,
  input  dvrt_pkg::cmd_t cmd,
  output dvrt_pkg::sts_t sts,
  input  logic           out_ready,
  output logic           out_valid,
  output dvrt_pkg::out_t out_data
);

  localparam int NE    = (NODES < dvrt_pkg::MAX_NODES) ? NODES : dvrt_pkg::MAX_NODES;
  localparam int DEPTH = NE * dvrt_pkg::MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [dvrt_pkg::CNT_W-1:0] NE_C = dvrt_pkg::CNT_W'(NE);

  dvrt_pkg::in_t  item_r;
  dvrt_pkg::out_t out_r, out_nxt;
  logic           out_valid_r;
  logic [2:0]     own_r;
  logic [7:0]     mask_r;
  logic [dvrt_pkg::CNT_W-1:0] d_r, b_r;
  logic [15:0]    cur_r, a_r;
  logic [16:0]    best_r, sum;
  logic [2:0]     via_r;
  logic           have_r;
  logic [2:0]     hop_r   [dvrt_pkg::MAX_NODES];
  logic           heard_r [dvrt_pkg::MAX_NODES];
  logic [2:0]     miss_r  [dvrt_pkg::MAX_NODES];
  logic           vld_r   [DEPTH];
  logic           rd_vld_r, rd_diag_r;

  logic [2:0]  rrow, rcol, wrow, wcol, dk, bk;
  logic [5:0]  raddr6, waddr6;
  logic [15:0] wdata, ram_q, eff;
  logic        re, we;
  logic        own_ok, dest_ok, peer_ok, tick_hit, relax_win;
  logic [2:0]  miss_inc;

  assign dk       = d_r[2:0];
  assign bk       = b_r[2:0];
  assign own_ok   = {1'b0, own_r} < NE_C;
  assign dest_ok  = {1'b0, item_r.dest} < NE_C;
  assign peer_ok  = {1'b0, item_r.peer} < NE_C;
  assign miss_inc = (miss_r[dk] == dvrt_pkg::MISS_MAX) ? dvrt_pkg::MISS_MAX : miss_r[dk] + 3'd1;
  assign tick_hit = own_ok && (dk != own_r) && mask_r[dk] && heard_r[dk];
  assign eff      = rd_vld_r ? ram_q : (rd_diag_r ? 16'd0 : dvrt_pkg::UNREACH);
  assign sum      = {1'b0, a_r} + {1'b0, eff};
  assign relax_win = have_r && (best_r < {1'b0, cur_r});

  always_comb begin
    rrow = own_r;
    rcol = item_r.dest;
    unique case (cmd.rd_sel)
      dvrt_pkg::RD_OWN_D: rcol = dk;
      dvrt_pkg::RD_OWN_B: rcol = bk;
      dvrt_pkg::RD_B_D: begin
        rrow = bk;
        rcol = dk;
      end
      default: begin
      end
    endcase
  end
  assign re     = cmd.rd_sel != dvrt_pkg::RD_NONE;
  assign raddr6 = {rrow, rcol};

  always_comb begin
    wrow  = own_r;
    wcol  = item_r.dest;
    wdata = dvrt_pkg::UNREACH;
    we    = 1'b0;
    unique case (cmd.wr_sel)
      dvrt_pkg::WR_ITEM: begin
        wdata = item_r.cost_in;
        if (item_r.operation == dvrt_pkg::OP_VECTOR) begin
          wrow = item_r.peer;
          we   = peer_ok && dest_ok;
        end else begin
          we = own_ok && dest_ok;
        end
      end
      dvrt_pkg::WR_DIS: we = 1'b1;
      dvrt_pkg::WR_TICK: begin
        wcol = dk;
        we   = tick_hit && (miss_inc > dvrt_pkg::MISS_LIMIT);
      end
      dvrt_pkg::WR_RELAX: begin
        wcol  = dk;
        wdata = best_r[15:0];
        we    = relax_win;
      end
      default: begin
      end
    endcase
  end
  assign waddr6 = {wrow, wcol};

  dvrt_ram #(
    .WIDTH(dvrt_pkg::COST_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr6[AW-1:0]),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr6[AW-1:0]),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (re) begin
      rd_diag_r <= rrow == rcol;
    end
    if (cmd.cap_cur) begin
      cur_r <= eff;
    end
    if (cmd.cap_a) begin
      a_r <= eff;
    end
    if (cmd.cmp_sum && (!have_r || sum < best_r)) begin
      best_r <= sum;
      via_r  <= bk;
    end
    if (cmd.d_set0) begin
      d_r <= '0;
    end else if (cmd.d_set1) begin
      d_r <= dvrt_pkg::CNT_W'(1);
    end else if (cmd.d_inc) begin
      d_r <= d_r + dvrt_pkg::CNT_W'(1);
    end
    if (cmd.b_set1) begin
      b_r <= dvrt_pkg::CNT_W'(1);
    end else if (cmd.b_inc) begin
      b_r <= b_r + dvrt_pkg::CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r       <= 3'd1;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      for (int i = 0; i < dvrt_pkg::MAX_NODES; i++) begin
        hop_r[i]   <= '0;
        heard_r[i] <= 1'b0;
        miss_r[i]  <= '0;
      end
      for (int i = 0; i < DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == dvrt_pkg::CFG_OWN_NODE) begin
          own_r <= cfg_data[2:0];
        end else begin
          mask_r <= cfg_data;
        end
      end
      if (re) begin
        rd_vld_r <= vld_r[raddr6[AW-1:0]];
      end
      if (we) begin
        vld_r[waddr6[AW-1:0]] <= 1'b1;
      end
      if (cmd.cap_cur) begin
        have_r <= 1'b0;
      end else if (cmd.cmp_sum) begin
        have_r <= 1'b1;
      end
      if (cmd.wr_sel == dvrt_pkg::WR_ITEM && we) begin
        if (item_r.operation == dvrt_pkg::OP_LOAD) begin
          hop_r[item_r.dest] <= item_r.dest;
        end
        if (item_r.operation == dvrt_pkg::OP_VECTOR) begin
          heard_r[item_r.peer] <= 1'b1;
          miss_r[item_r.peer]  <= '0;
        end
      end
      if (cmd.wr_sel == dvrt_pkg::WR_TICK && tick_hit) begin
        miss_r[dk] <= miss_inc;
      end
      if (cmd.wr_sel == dvrt_pkg::WR_RELAX && relax_win) begin
        hop_r[dk] <= via_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    unique case (item_r.operation)
      dvrt_pkg::OP_DISABLE: out_nxt.status = !(own_ok && dest_ok && mask_r[item_r.dest]);
      dvrt_pkg::OP_READ: begin
        if (own_ok && dest_ok) begin
          out_nxt.next_hop = hop_r[item_r.dest];
          out_nxt.cost_out = eff;
        end else begin
          out_nxt.cost_out = dvrt_pkg::UNREACH;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.op       = item_r.operation;
  assign sts.last     = item_r.last;
  assign sts.vec_ok   = peer_ok && dest_ok;
  assign sts.dis_ok   = own_ok && dest_ok && mask_r[item_r.dest];
  assign sts.own_ok   = own_ok;
  assign sts.d_end    = d_r >= NE_C;
  assign sts.d_is_own = d_r == {1'b0, own_r};
  assign sts.b_end    = b_r >= NE_C;
  assign sts.b_nbr    = mask_r[bk];
  assign sts.out_full = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* src/distance_vector_route_table.sv */
// Distance-vector route table for one router. Each transfer on in_* yields exactly one
// transfer on out_*; one operation is in work at a time, and the next is taken as soon
// as the previous result sits in the output register. Cost table lives in a RAM with one
// registered read port and one write port, never used together. A relaxation walks each
// destination from node 1 up, other than the own node, reading its current cost, then for
// each neighbor the link cost and the neighbor's cost to it; the smallest sum is written
// back if it beats the current cost. Node count is NODES capped at 8. The table needs no
// clearing pass: entries never written read as 0 on the diagonal and 65535 elsewhere.
// Configuration (index 0 own node, 1 neighbor mask) is always ready.
module distance_vector_route_table #(
  parameter int NODES = dvrt_pkg::NODES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dvrt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dvrt_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data
);

  dvrt_pkg::cmd_t cmd;
  dvrt_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  dvrt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  dvrt_dp #(
    .NODES(NODES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

/* test/tb_distance_vector_route_table_chk.sv */
module tb_distance_vector_route_table_chk (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  dvrt_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  dvrt_pkg::out_t out_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data,
  output int             fail_count,
  output int             pending
);

  localparam int N = 8;

  logic [dvrt_pkg::COST_W-1:0] cost_mem [N][N];
  logic [2:0]        hop_mem  [N];
  logic              heard    [N];
  logic [2:0]        misses   [N];
  logic [2:0]        own;
  logic [7:0]        nbr_mask;
  dvrt_pkg::out_t    route_q [$];

  function automatic bit is_nbr(logic [2:0] n);
    return nbr_mask[n];
  endfunction

  function automatic void relax_routes();
    logic [16:0] best, s;
    logic [2:0]  via;
    bit          have;
    for (int d = 1; d < N; d++) begin
      if (d == own) continue;
      have = 0;
      best = '0;
      via  = '0;
      for (int b = 1; b < N; b++) begin
        if (!is_nbr(3'(b))) continue;
        s = {1'b0, cost_mem[own][b]} + {1'b0, cost_mem[b][d]};
        if (!have || s < best) begin
          have = 1;
          best = s;
          via  = 3'(b);
        end
      end
      if (have && best < {1'b0, cost_mem[own][d]}) begin
        cost_mem[own][d] = best[15:0];
        hop_mem[d] = via;
      end
    end
  endfunction

  function automatic void age_links();
    for (int k = 0; k < N; k++) begin
      if (k == own || !is_nbr(3'(k)) || !heard[k]) continue;
      if (misses[k] < dvrt_pkg::MISS_MAX) misses[k]++;
      if (misses[k] > dvrt_pkg::MISS_LIMIT) cost_mem[own][k] = dvrt_pkg::UNREACH;
    end
  endfunction

  function automatic dvrt_pkg::out_t route_step(dvrt_pkg::in_t it);
    dvrt_pkg::out_t r;
    r = '0;
    case (it.operation)
      dvrt_pkg::OP_LOAD: begin
        cost_mem[own][it.dest] = it.cost_in;
        hop_mem[it.dest] = it.dest;
      end
      dvrt_pkg::OP_SET: cost_mem[own][it.dest] = it.cost_in;
      dvrt_pkg::OP_DISABLE: begin
        if (is_nbr(it.dest)) begin
          cost_mem[own][it.dest] = dvrt_pkg::UNREACH;
          relax_routes();
        end else begin
          r.status = 1'b1;
        end
      end
      dvrt_pkg::OP_VECTOR: begin
        cost_mem[it.peer][it.dest] = it.cost_in;
        heard[it.peer] = 1'b1;
        misses[it.peer] = '0;
        if (it.last) relax_routes();
      end
      dvrt_pkg::OP_TICK: age_links();
      dvrt_pkg::OP_READ: begin
        r.next_hop = hop_mem[it.dest];
        r.cost_out = cost_mem[own][it.dest];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    dvrt_pkg::out_t e;
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) cost_mem[i][j] = (i == j) ? '0 : dvrt_pkg::UNREACH;
        hop_mem[i] = '0;
        heard[i] = 1'b0;
        misses[i] = '0;
      end
      own = 3'd1;
      nbr_mask = '0;
      route_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == dvrt_pkg::CFG_OWN_NODE) own = cfg_data[2:0];
        else nbr_mask = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (route_q.size() == 0) begin
          report("unexpected transfer", 1, 0);
        end else begin
          e = route_q.pop_front();
          if (out_data.status !== e.status)
            report("status", int'(out_data.status), int'(e.status));
          if (out_data.next_hop !== e.next_hop)
            report("next_hop", int'(out_data.next_hop), int'(e.next_hop));
          if (out_data.cost_out !== e.cost_out)
            report("cost_out", int'(out_data.cost_out), int'(e.cost_out));
        end
      end
      if (in_valid && in_ready) route_q.push_back(route_step(in_data));
    end
    pending = route_q.size();
  end

endmodule

/* test/tb_distance_vector_route_table.sv */
module tb_distance_vector_route_table;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  dvrt_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  dvrt_pkg::out_t out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic           cfg_index;
  logic [7:0]     cfg_data;
  int             fail_count;
  int             pending;
  int             cycles;
  int             send_idle_pct;
  int             recv_stall_pct;

  localparam int LIMIT = 3_000_000;

  distance_vector_route_table u_top (.*);

  tb_distance_vector_route_table_chk u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb_distance_vector_route_table: done, errors");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_op(logic [2:0] op, int peer, int dest, int cost, int last);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= '{operation: op, peer: 3'(peer), dest: 3'(dest), cost_in: 16'(cost),
                  last: 1'(last)};
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic int rand_cost();
    case ($urandom_range(5))
      0: return 65535;
      1: return 65534;
      2: return 0;
      3: return int'($urandom_range(65535));
      default: return int'($urandom_range(40));
    endcase
  endfunction

  task automatic random_ops(int count);
    int p;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) != 0) begin
        p = int'($urandom_range(7));
        for (int d = 0; d < 8; d++)
          send_op(dvrt_pkg::OP_VECTOR, p, d, rand_cost(), int'(d == 7));
        send_op(dvrt_pkg::OP_READ, 0, int'($urandom_range(7)), 0, 0);
        i += 8;
      end else begin
        send_op(3'($urandom_range(7)), int'($urandom_range(7)), int'($urandom_range(7)),
                rand_cost(), int'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = dvrt_pkg::CFG_OWN_NODE;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int d = 0; d < 8; d++) send_op(dvrt_pkg::OP_READ, 0, d, 0, 0);
    send_op(dvrt_pkg::OP_DISABLE, 0, 2, 0, 0);
    send_op(dvrt_pkg::OP_TICK, 0, 0, 0, 0);
    send_op(3'd6, 7, 7, 65535, 1);
    send_op(3'd7, 0, 0, 0, 0);
    drain();
    write_reg(dvrt_pkg::CFG_NBR_MASK, 8'hFF);
    write_reg(dvrt_pkg::CFG_OWN_NODE, 8'd7);
    send_op(dvrt_pkg::OP_LOAD, 0, 1, 1, 0);
    send_op(dvrt_pkg::OP_LOAD, 0, 2, 65534, 0);
    send_op(dvrt_pkg::OP_SET, 0, 3, 0, 0);
    send_op(dvrt_pkg::OP_VECTOR, 1, 4, 5, 0);
    send_op(dvrt_pkg::OP_VECTOR, 7, 5, 9, 0);
    send_op(dvrt_pkg::OP_VECTOR, 2, 0, 65535, 1);
    send_op(dvrt_pkg::OP_DISABLE, 0, 1, 0, 0);
    send_op(dvrt_pkg::OP_DISABLE, 0, 0, 0, 0);
    for (int t = 0; t < 5; t++) send_op(dvrt_pkg::OP_TICK, 0, 0, 0, 0);
    send_op(dvrt_pkg::OP_READ, 0, 4, 0, 0);
    send_op(dvrt_pkg::OP_READ, 0, 5, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      write_reg(dvrt_pkg::CFG_OWN_NODE,
                (ph == 0) ? 8'd1 : (ph == 1) ? 8'd7 : 8'($urandom_range(1, 7)));
      write_reg(dvrt_pkg::CFG_NBR_MASK,
                (ph == 2) ? 8'h00 : (ph == 3) ? 8'hFF : 8'($urandom_range(255)));
      random_ops(115);
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_distance_vector_route_table: done, clean");
    end else begin
      $display("tb_distance_vector_route_table: done, errors");
    end
    $finish;
  end

endmodule
